// ----- sv/versioned_linear_probe_hash_table_core_assert.svh -----
// Assertion macros for the checker file.
`ifndef VERSIONED_LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define VERSIONED_LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Condition must hold in the same cycle.
`define VLPHT_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");

// Condition must hold in the following cycle.
`define VLPHT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// ----- sv/vlpht_pkg.sv -----
package vlpht_pkg;

  localparam int INDEX_BITS = 10;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 20;
  localparam int TAG_BITS   = 8;
  localparam int CMD_BITS   = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_PROBE,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [TAG_BITS-1:0]   tag;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic                  stored;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    slot_t                 wdata;
    logic [INDEX_BITS-1:0] raddr;
  } ram_req_t;

endpackage

// ----- sv/vlpht_in_if.sv -----
interface vlpht_in_if import vlpht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   cmd;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

// ----- sv/vlpht_out_if.sv -----
interface vlpht_out_if import vlpht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] value_out;
  logic                  stored;

  modport source (output valid, output found, output value_out, output stored, input ready);
  modport sink (input valid, input found, input value_out, input stored, output ready);
endinterface

// ----- sv/vlpht_ram.sv -----
module vlpht_ram #(
  parameter int WIDTH     = 60,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/vlpht_ctrl.sv -----
module vlpht_ctrl import vlpht_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_BITS-1:0]   cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o,
  output ram_req_t              ram_req_o,
  input  slot_t                 rd_data_i
);

  localparam logic [TAG_BITS-1:0] TAG_FIRST = TAG_BITS'(1);

  state_e                state_q, state_d;
  logic [CMD_BITS-1:0]   cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [INDEX_BITS-1:0] cnt_q, cnt_d;
  logic [TAG_BITS-1:0]   live_q, live_d;
  logic                  sweep_reply_q, sweep_reply_d;
  result_t               res_q, res_d;

  logic accept;
  logic tag_live;
  logic key_eq;
  logic stop;
  logic last;
  logic live_wrap;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign tag_live  = (rd_data_i.tag == live_q);
  assign key_eq    = (rd_data_i.key == key_q);
  assign stop      = !tag_live || key_eq;
  assign last      = &cnt_q;
  assign live_wrap = &live_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_FIND, CMD_INSERT: state_d = ST_READ;
            CMD_CLEAR:            state_d = live_wrap ? ST_SWEEP : ST_REPLY;
            default:              state_d = ST_REPLY;
          endcase
        end
      end
      ST_SWEEP: begin
        if (&pos_q) begin
          state_d = sweep_reply_q ? ST_REPLY : ST_IDLE;
        end
      end
      ST_READ:  state_d = ST_PROBE;
      ST_PROBE: begin
        if (stop || last) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    res_valid_o     = (state_q == ST_REPLY);
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = pos_q;
    ram_req_o.wdata = '{key: key_q, value: value_q, tag: live_q};
    ram_req_o.raddr = pos_q;
    unique case (state_q)
      ST_SWEEP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = '0;
      end
      ST_PROBE: begin
        ram_req_o.we    = stop && (cmd_q == CMD_INSERT);
        ram_req_o.raddr = pos_q + INDEX_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    live_d        = live_q;
    sweep_reply_d = sweep_reply_q;
    res_d         = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = key_i[INDEX_BITS-1:0];
          cnt_d = '0;
          res_d = '0;
          if (cmd_i == CMD_CLEAR) begin
            // wrap restarts the generation and forces a tag sweep
            live_d = live_wrap ? TAG_FIRST : live_q + TAG_FIRST;
            if (live_wrap) begin
              pos_d         = '0;
              sweep_reply_d = 1'b1;
            end
          end
        end
      end
      ST_SWEEP: pos_d = pos_q + INDEX_BITS'(1);
      ST_PROBE: begin
        if (stop) begin
          res_d.found     = (cmd_q == CMD_FIND) && tag_live;
          res_d.value_out = ((cmd_q == CMD_FIND) && tag_live) ? rd_data_i.value : '0;
          res_d.stored    = (cmd_q == CMD_INSERT);
        end else begin
          pos_d = pos_q + INDEX_BITS'(1);
          cnt_d = cnt_q + INDEX_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      pos_q         <= '0;
      cnt_q         <= '0;
      live_q        <= TAG_FIRST;
      sweep_reply_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      cnt_q         <= cnt_d;
      live_q        <= live_d;
      sweep_reply_q <= sweep_reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- sv/versioned_linear_probe_hash_table_core.sv -----
// Open-addressing hash table, 2^INDEX_BITS slots, linear probing from the key's low
// bits, one result word per command word. Every slot read goes through the single
// read port of the slot RAM, so the probe loop visits one slot per cycle. A find or
// insert takes the word in the idle state, issues the first read in the read state,
// visits slots in the probe state (P, 1 to 2^INDEX_BITS), then hands the result to
// the output register from the reply state. A clear or an unused command goes to the
// reply state unless the generation wraps, which adds a tag sweep over all
// 2^INDEX_BITS slots (1024 slots here); the same sweep runs after reset, and no
// command word is taken until it ends. While the output register holds an unread
// word, the block waits in its reply state.
// An insert that meets a full table writes nothing and returns stored = 0.
module versioned_linear_probe_hash_table_core import vlpht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vlpht_in_if.sink   in_i,
  vlpht_out_if.source out_o
);

  ram_req_t             ram_req;
  logic [SLOT_BITS-1:0] rd_raw;
  slot_t                rd_data;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  logic                 out_valid_q;
  result_t              out_q;

  vlpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_i      (in_i.cmd),
    .key_i      (in_i.key),
    .value_i    (in_i.value),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_req_o  (ram_req),
    .rd_data_i  (rd_data)
  );

  vlpht_ram #(
    .WIDTH    (SLOT_BITS),
    .ADDR_BITS(INDEX_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(rd_raw)
  );

  assign rd_data   = slot_t'(rd_raw);
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = out_q.found;
  assign out_o.value_out = out_q.value_out;
  assign out_o.stored    = out_q.stored;

endmodule

// ----- sv/vlpht_checker.sv -----
`include "versioned_linear_probe_hash_table_core_assert.svh"

module vlpht_checker import vlpht_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  found_i,
  input logic [VALUE_BITS-1:0] value_out_i,
  input logic                  stored_i
);

  // one command word at a time
  `VLPHT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  `VLPHT_ASSERT_NOW(a_hit_or_store, clk_i, rst_ni, out_valid_i, !(found_i && stored_i))

  `VLPHT_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, value_out_i == '0)

  `VLPHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({found_i, value_out_i, stored_i}))

endmodule

bind versioned_linear_probe_hash_table_core vlpht_checker u_vlpht_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .found_i    (out_o.found),
  .value_out_i(out_o.value_out),
  .stored_i   (out_o.stored)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import vlpht_pkg::*;

  localparam int unsigned SLOTS = 1 << INDEX_BITS;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_COMB} rx_mode_e;

  // Shadow of the slot table; one reply word is owed per command word.
  class probe_table_sb;
    bit [KEY_BITS-1:0]   slot_key [SLOTS];
    bit [VALUE_BITS-1:0] slot_val [SLOTS];
    bit [TAG_BITS-1:0]   slot_gen [SLOTS];
    bit [TAG_BITS-1:0]   live_gen;
    int unsigned         live_count;
    int unsigned         wraps;
    int unsigned         mismatches;
    result_t             pending [$];

    function new();
      foreach (slot_gen[i]) slot_gen[i] = '0;
      live_gen   = 1;
      live_count = 0;
      wraps      = 0;
      mismatches = 0;
    endfunction

    function void log_command(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
                              logic [VALUE_BITS-1:0] value);
      result_t     r;
      int unsigned pos;
      r   = '0;
      pos = key[INDEX_BITS-1:0];
      case (cmd)
        CMD_FIND: begin
          for (int n = 0; n < SLOTS; n++) begin
            if (slot_gen[pos] != live_gen) break;
            if (slot_key[pos] == key) begin
              r.found     = 1'b1;
              r.value_out = slot_val[pos];
              break;
            end
            pos = (pos + 1) % SLOTS;
          end
        end
        CMD_INSERT: begin
          for (int n = 0; n < SLOTS; n++) begin
            if (slot_gen[pos] != live_gen || slot_key[pos] == key) begin
              if (slot_gen[pos] != live_gen) live_count++;
              slot_key[pos] = key;
              slot_val[pos] = value;
              slot_gen[pos] = live_gen;
              r.stored      = 1'b1;
              break;
            end
            pos = (pos + 1) % SLOTS;
          end
        end
        CMD_CLEAR: begin
          live_gen   = live_gen + 1'b1;
          live_count = 0;
          // restart at one and age out every slot on wrap
          if (live_gen == '0) begin
            live_gen = 1;
            foreach (slot_gen[i]) slot_gen[i] = '0;
            wraps++;
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("reply word with nothing outstanding: found=%0d value_out=%h stored=%0d",
               got.found, got.value_out, got.stored);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %h, got %h", want.value_out, got.value_out);
        mismatches++;
      end
      if (got.stored !== want.stored) begin
        $error("stored: expected %0d, got %0d", want.stored, got.stored);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vlpht_in_if  cmd_if ();
  vlpht_out_if reply_if ();

  versioned_linear_probe_hash_table_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (reply_if)
  );

  probe_table_sb table_sb;
  int unsigned   burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_800_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [VALUE_BITS-1:0] rand_value();
    return VALUE_BITS'($urandom());
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    return KEY_BITS'($urandom());
  endfunction

  function automatic logic [KEY_BITS-1:0] key_at(int unsigned home);
    logic [KEY_BITS-1:0] k;
    k = rand_key();
    k[INDEX_BITS-1:0] = INDEX_BITS'(home % SLOTS);
    return k;
  endfunction

  task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= cmd;
    cmd_if.key   <= key;
    cmd_if.value <= value;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    table_sb.log_command(cmd, key, value);
  endtask

  // Hold the sender until every reply word is back.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (table_sb.pending.size() != 0);
  endtask

  // Traffic clustered on 1 to 48 neighboring home slots so probe chains form.
  task automatic mixed_round(int unsigned n_items);
    int unsigned         base;
    int unsigned         width;
    int unsigned         pick;
    logic [KEY_BITS-1:0] known [$];
    logic [KEY_BITS-1:0] k;
    base  = ($urandom_range(0, 3) == 0) ? SLOTS - 8 : $urandom_range(0, SLOTS - 1);
    width = $urandom_range(1, 48);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (known.size() > 0 && $urandom_range(0, 1) == 1)
        k = known[$urandom_range(0, known.size() - 1)];
      else
        k = key_at(base + $urandom_range(0, width - 1));
      if (pick < 45) begin
        send_word(CMD_INSERT, k, rand_value());
        known = {known, k};
      end else if (pick < 90) begin
        send_word(CMD_FIND, k, rand_value());
      end else if (pick < 97) begin
        send_word(CMD_CLEAR, rand_key(), rand_value());
      end else begin
        send_word(CMD_UNUSED, k, rand_value());
      end
    end
  endtask

  task automatic clear_until_wrap();
    int unsigned w0;
    w0 = table_sb.wraps;
    while (table_sb.wraps == w0) send_word(CMD_CLEAR, rand_key(), rand_value());
  endtask

  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned tick;
    reply_if.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          RX_OPEN:  reply_if.ready <= 1'b1;
          RX_LIGHT: reply_if.ready <= ($urandom_range(0, 4) != 0);
          RX_HALF:  reply_if.ready <= ($urandom_range(0, 1) == 1);
          default:  reply_if.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && reply_if.valid && reply_if.ready)
      table_sb.check_reply({reply_if.found, reply_if.value_out, reply_if.stored});
  end

  initial begin
    logic [KEY_BITS-1:0] kept [$];
    logic [KEY_BITS-1:0] k;
    table_sb = new();
    rst_ni = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd   <= '0;
    cmd_if.key   <= '0;
    cmd_if.value <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // home 1023 is taken, so the third insert wraps past slot 0 into slot 1
    send_word(CMD_FIND, '0, '0);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_INSERT, 32'h0000_03FF, 20'h5A5A5);
    send_word(CMD_FIND, 32'h0000_03FF, '0);
    send_word(CMD_FIND, 32'h8000_03FF, '1);
    send_word(CMD_INSERT, '1, 20'h12345);
    send_word(CMD_FIND, '1, '0);
    send_word(CMD_UNUSED, '1, '1);
    send_word(CMD_FIND, '0, '1);
    send_word(CMD_FIND, '1, '0);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_FIND, '1, '0);
    send_word(CMD_INSERT, 32'h0000_03FF, 20'h0F0F0);
    send_word(CMD_INSERT, 32'hAAAA_AAAA, 20'hAAAAA);
    send_word(CMD_INSERT, 32'h5555_5555, 20'h55555);
    send_word(CMD_FIND, 32'hAAAA_AAAA, '0);
    send_word(CMD_FIND, 32'h5555_5555, '0);
    send_word(CMD_FIND, 32'h0000_03FF, '0);
    wait_idle();

    repeat (2) mixed_round($urandom_range(40, 80));
    wait_idle();

    // entries of generation one must not revive after the next wrap
    clear_until_wrap();
    repeat (8) begin
      k = key_at($urandom_range(0, SLOTS - 1));
      kept = {kept, k};
      send_word(CMD_INSERT, k, rand_value());
    end
    foreach (kept[i]) send_word(CMD_FIND, kept[i], rand_value());
    clear_until_wrap();
    foreach (kept[i]) send_word(CMD_FIND, kept[i], rand_value());
    send_word(CMD_INSERT, kept[0], rand_value());
    send_word(CMD_FIND, kept[0], rand_value());
    wait_idle();

    // fill every slot, then probe the full table
    kept.delete();
    send_word(CMD_CLEAR, rand_key(), rand_value());
    while (table_sb.live_count < SLOTS) begin
      k = rand_key();
      kept = {kept, k};
      send_word(CMD_INSERT, k, rand_value());
    end
    repeat (6) begin
      send_word(CMD_INSERT, rand_key(), rand_value());
      send_word(CMD_FIND, rand_key(), rand_value());
    end
    repeat (8) begin
      k = kept[$urandom_range(0, kept.size() - 1)];
      send_word(CMD_FIND, k, rand_value());
      send_word(CMD_INSERT, k, rand_value());
      send_word(CMD_FIND, k, rand_value());
    end
    send_word(CMD_CLEAR, rand_key(), rand_value());
    wait_idle();

    repeat (1) mixed_round($urandom_range(40, 80));

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/vlpht_pkg.sv
sv/vlpht_in_if.sv
sv/vlpht_out_if.sv
sv/vlpht_ram.sv
sv/vlpht_ctrl.sv
sv/versioned_linear_probe_hash_table_core.sv
sv/vlpht_checker.sv
dv/tb.sv
